FILE: src/smc_pkg.sv
// Package for the substring match counter.
// Shared widths, defaults and register indexes; no dependencies.
`default_nettype none
package smc_pkg;
	localparam int BYTE_W           = 8;
	localparam int PAT_W            = 64;
	localparam int LEN_W            = 4;
	localparam int CNT_W            = 16;
	localparam int POS_OUT_W        = 16;
	localparam int CFG_IDX_W        = 1;
	localparam int MAX_PATTERN_DEF  = 8;
	localparam int POSITION_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 1'd1;

	localparam logic [LEN_W-1:0] SINCE_NONE = 4'd8;
	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
endpackage
`default_nettype wire

FILE: src/smc_text_if.sv
// Input channel of the substring match counter: one text byte per request.
// Depends on smc_pkg.
`default_nettype none
interface smc_text_if;
	import smc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              last_byte;

	modport source (output valid, text_byte, last_byte, input ready);
	modport sink   (input valid, text_byte, last_byte, output ready);
endinterface
`default_nettype wire

FILE: src/smc_result_if.sv
// Result channel of the substring match counter: one result per text byte.
// Depends on smc_pkg.
`default_nettype none
interface smc_result_if;
	import smc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 match_hit;
	logic [POS_OUT_W-1:0] match_start;
	logic [CNT_W-1:0]     match_count;
	logic                 first_found;
	logic [POS_OUT_W-1:0] first_index;
	logic [CNT_W-1:0]     token_count;
	logic                 done_res;
	logic                 too_long;

	modport source (output valid, match_hit, match_start, match_count, first_found,
		first_index, token_count, done_res, too_long, input ready);
	modport sink   (input valid, match_hit, match_start, match_count, first_found,
		first_index, token_count, done_res, too_long, output ready);
endinterface
`default_nettype wire

FILE: src/substring_match_counter_top.sv
// Substring match counter: streaming leftmost non-overlapping pattern search.
// Path: a text request passes the window cells, then the result register.
// Throughput: one text byte per cycle while the result side is ready; the cell row compares all slots in parallel.
// Reset: window, match counters and position clear, the since counter goes to SINCE_NONE; pattern = 0, pattern_len = 1.
// Depends on smc_pkg, smc_text_if, smc_result_if, smc_cell.
`default_nettype none
module substring_match_counter_top #(
	parameter int MAX_PATTERN   = smc_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = smc_pkg::POSITION_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [smc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [smc_pkg::PAT_W-1:0]    cfg_wdata,
	smc_text_if.sink                          text,
	smc_result_if.source                      result
);
	import smc_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// configuration
	logic [PAT_W-1:0] pattern_q;
	logic [LEN_W-1:0] pattern_len_q;
	logic [LEN_W-1:0] n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pattern_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PATTERN:     pattern_q     <= cfg_wdata;
				REG_PATTERN_LEN: pattern_len_q <= cfg_wdata[LEN_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		priority if (pattern_len_q == '0) begin
			n = LEN_W'(1);
		end else if (pattern_len_q > LEN_W'(MAX_PATTERN)) begin
			n = LEN_W'(MAX_PATTERN);
		end else begin
			n = pattern_len_q;
		end
	end

	// handshake
	logic v_s1, out_v_q;
	logic adv_s2, in_acc;

	assign adv_s2     = v_s1 && (!out_v_q || result.ready);
	assign text.ready = !v_s1 || adv_s2;
	assign in_acc     = text.valid && text.ready;

	// stage 1: cell row and position
	logic [BYTE_W-1:0]        win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]   ok;
	logic                     last_acc_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     sat;
	logic [POSITION_BITS-1:0] idx_s1;
	logic                     sat_s1;
	logic                     last_s1;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [BYTE_W-1:0] feed;
		if (j == 0) begin : g_head
			assign feed = text.text_byte;
		end else begin : g_body
			assign feed = last_acc_q ? '0 : win[j-1];
		end
		smc_cell #(.POS(j)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (in_acc),
			.byte_in (feed),
			.pattern (pattern_q),
			.len     (n),
			.byte_q  (win[j]),
			.ok      (ok[j])
		);
	end

	assign sat = (pos_q == POS_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			last_acc_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (in_acc) begin
				v_s1       <= 1'b1;
				last_acc_q <= text.last_byte;
				if (text.last_byte) begin
					pos_q <= '0;
				end else if (!sat) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
			end else if (adv_s2) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1  <= pos_q;
			sat_s1  <= sat;
			last_s1 <= text.last_byte;
		end
	end

	// stage 2: match decision, counters, result register
	logic [LEN_W-1:0]         since_q, since_inc, since_nx;
	logic [CNT_W-1:0]         total_q, total_nx, tokens;
	logic                     first_q, first_nx;
	logic [POSITION_BITS-1:0] first_pos_q, first_pos_nx;
	logic                     ovf_q, ovf_nx;
	logic [LEN_W-1:0]         nm1;
	logic                     long_enough, hit;
	logic [POSITION_BITS-1:0] start;

	always_comb begin
		nm1          = n - LEN_W'(1);
		since_inc    = (since_q < SINCE_NONE) ? since_q + LEN_W'(1) : since_q;
		long_enough  = sat_s1 || (idx_s1 >= POSITION_BITS'(nm1));
		hit          = long_enough && (since_inc >= n) && (&ok);
		start        = sat_s1 ? POS_MAX : idx_s1 - POSITION_BITS'(nm1);
		since_nx     = hit ? '0 : since_inc;
		total_nx     = (hit && total_q != CNT_MAX) ? total_q + CNT_W'(1) : total_q;
		first_nx     = first_q || hit;
		first_pos_nx = (hit && !first_q) ? start : first_pos_q;
		ovf_nx       = ovf_q || sat_s1;
		if (total_nx == '0) begin
			tokens = '0;
		end else if (total_nx == CNT_MAX) begin
			tokens = CNT_MAX;
		end else begin
			tokens = total_nx + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			since_q     <= SINCE_NONE;
			total_q     <= '0;
			first_q     <= 1'b0;
			first_pos_q <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (adv_s2) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (adv_s2) begin
				if (last_s1) begin
					since_q     <= SINCE_NONE;
					total_q     <= '0;
					first_q     <= 1'b0;
					first_pos_q <= '0;
					ovf_q       <= 1'b0;
				end else begin
					since_q     <= since_nx;
					total_q     <= total_nx;
					first_q     <= first_nx;
					first_pos_q <= first_pos_nx;
					ovf_q       <= ovf_nx;
				end
			end
		end
	end

	logic                 hit_q, first_found_q, done_q, too_long_q;
	logic [POS_OUT_W-1:0] start_q, first_index_q;
	logic [CNT_W-1:0]     count_q, tokens_q;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			hit_q         <= hit;
			start_q       <= hit ? POS_OUT_W'(start) : '0;
			count_q       <= total_nx;
			first_found_q <= first_nx;
			first_index_q <= first_nx ? POS_OUT_W'(first_pos_nx) : '0;
			tokens_q      <= tokens;
			done_q        <= last_s1;
			too_long_q    <= ovf_nx;
		end
	end

	assign result.valid       = out_v_q;
	assign result.match_hit   = hit_q;
	assign result.match_start = start_q;
	assign result.match_count = count_q;
	assign result.first_found = first_found_q;
	assign result.first_index = first_index_q;
	assign result.token_count = tokens_q;
	assign result.done_res    = done_q;
	assign result.too_long    = too_long_q;
endmodule
`default_nettype wire

FILE: src/smc_cell.sv
// One window cell: holds one text byte, passes it on, compares it with the
// pattern byte that lines up with its slot. Depends on smc_pkg.
`default_nettype none
module smc_cell #(
	parameter int POS = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic [smc_pkg::BYTE_W-1:0] byte_in,
	input  wire logic [smc_pkg::PAT_W-1:0]  pattern,
	input  wire logic [smc_pkg::LEN_W-1:0]  len,
	output logic      [smc_pkg::BYTE_W-1:0] byte_q,
	output logic                            ok
);
	import smc_pkg::*;

	logic [LEN_W-1:0]  sel;
	logic [BYTE_W-1:0] want;
	logic              active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// slot POS of the window meets pattern byte len-1-POS
	assign sel    = len - LEN_W'(POS) - LEN_W'(1);
	assign want   = pattern[{sel[2:0], 3'b000} +: BYTE_W];
	assign active = len > LEN_W'(POS);
	assign ok     = !active || (byte_q == want);
endmodule
`default_nettype wire
